// ----- rtl/ph_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ph_pkg - shared definitions for the pixel histogram engine
// Default sizes, command codes, register reset values and the control
// bundle that the clear sequencer hands to the datapath.
// ----------------------------------------------------------------------------
package ph_pkg;

    // default histogram geometry
    localparam int PH_NUM_BINS    = 256;
    localparam int PH_COUNT_WIDTH = 32;

    // field widths fixed by the stream format
    localparam int PH_PIXEL_W     = 8;
    localparam int PH_OUT_COUNT_W = 32;
    localparam int PH_S_TDATA_W   = 16;
    localparam int PH_M_TDATA_W   = 40;

    // command codes carried on s_axis_tuser
    localparam logic PH_CMD_COUNT = 1'b0;
    localparam logic PH_CMD_READ  = 1'b1;

    // configuration reset value
    localparam logic [PH_PIXEL_W-1:0] PH_MAX_LEVEL_RESET = 8'hFF;

    // clear sequencer to datapath
    typedef struct packed {
        logic busy;
        logic wr_en;
    } ph_clr_ctrl_t;

endpackage : ph_pkg
`default_nettype wire

// ----- rtl/ph_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ph_ram - generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered and holds its
// value while no read is issued. A read of an entry being written in the
// same cycle returns the old contents.
// ----------------------------------------------------------------------------
module ph_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule : ph_ram
`default_nettype wire

// ----- rtl/ph_clear.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ph_clear - post-reset clearing sweep for the bin memory
// Walks every bin address once after reset and asks for a zero write at
// each; reports busy until the last bin has been cleared.
// ----------------------------------------------------------------------------
module ph_clear #(
    parameter int NUM_BINS = ph_pkg::PH_NUM_BINS
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    output ph_pkg::ph_clr_ctrl_t             ctrl,
    output logic      [$clog2(NUM_BINS)-1:0] addr
);
    import ph_pkg::*;

    localparam int ADDR_W = $clog2(NUM_BINS);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_BINS - 1);

    logic              busy_reg;
    logic              busy_next;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] addr_next;

    // advance through the bins, drop busy after the last one
    always_comb
    begin
        busy_next = busy_reg;
        addr_next = addr_reg;
        if (busy_reg)
        begin
            addr_next = addr_reg + 1'b1;
            if (addr_reg == LAST_ADDR)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            addr_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            addr_reg <= addr_next;
        end
    end

    assign ctrl.busy  = busy_reg;
    assign ctrl.wr_en = busy_reg;
    assign addr       = addr_reg;

endmodule : ph_clear
`default_nettype wire

// ----- rtl/pixel_histogram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_histogram - histogram engine for 8-bit grey pixels
// Counts pixels into saturating bins held in one RAM and reads bins back.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel. s_axis_tuser selects the command:
//   count adds one to the bin of pixel_value, read returns one bin.
//   Count requests give no response; read requests give one response on
//   m_axis with the bin count and the sticky overflow flag.
//   Throughput is one request per cycle, count and read mixed freely; the
//   bin RAM is read in the accept cycle and written back in the next one,
//   with a one-entry forward path covering back-to-back hits on one bin.
//   A read response passes through stage 1 and then the output register.
//   After reset the bins are zeroed by a sweep over every bin, during
//   which s_axis_tready is low; max_level returns to 255, the flag to 0.
//   When the receiver stalls the response waits in the output register;
//   count requests keep flowing, and the next read waits in stage 1 with
//   s_axis_tready low until the response is taken. cfg_wr_en writes
//   max_level; write it only while no request is in flight.
// ----------------------------------------------------------------------------
module pixel_histogram #(
    parameter int NUM_BINS    = ph_pkg::PH_NUM_BINS,
    parameter int COUNT_WIDTH = ph_pkg::PH_COUNT_WIDTH
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // request channel
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [ph_pkg::PH_S_TDATA_W-1:0]   s_axis_tdata,  // pixel_value, bin_index
    input  wire logic                              s_axis_tuser,  // cmd
    // response channel
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic      [ph_pkg::PH_M_TDATA_W-1:0]   m_axis_tdata,  // bin_count, overflow_seen, zero pad
    // configuration
    input  wire logic                              cfg_wr_en,
    input  wire logic [ph_pkg::PH_PIXEL_W-1:0]     cfg_wr_data    // max_level
);
    import ph_pkg::*;

    localparam int ADDR_W = $clog2(NUM_BINS);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // request fields
    logic [PH_PIXEL_W-1:0]        pixel_value;
    logic [PH_PIXEL_W-1:0]        bin_index;
    logic [ADDR_W+PH_PIXEL_W-1:0] pix_ext;
    logic [ADDR_W+PH_PIXEL_W-1:0] idx_ext;
    logic [ADDR_W-1:0]            req_addr;
    logic                         req_ok;
    logic                         accept;

    // stage 1 (memory data returned)
    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    logic                   s1_cmd_reg;
    logic [ADDR_W-1:0]      s1_addr_reg;
    logic                   s1_ok_reg;
    logic                   s1_go;
    logic [COUNT_WIDTH-1:0] s1_count;

    // forwarding of the write that overlapped the read
    logic                   fwd_hit_reg;
    logic [COUNT_WIDTH-1:0] fwd_data_reg;

    // memory ports
    ph_clr_ctrl_t           clr_ctrl;
    logic [ADDR_W-1:0]      clr_addr;
    logic                   upd_en;
    logic                   ram_wr_en;
    logic [ADDR_W-1:0]      ram_wr_addr;
    logic [COUNT_WIDTH-1:0] ram_wr_data;
    logic [COUNT_WIDTH-1:0] ram_rd_data;

    // status, config and output
    logic                          flag_reg;
    logic                          flag_next;
    logic [PH_PIXEL_W-1:0]         max_level_reg;
    logic                          m_valid_reg;
    logic                          m_valid_next;
    logic [PH_OUT_COUNT_W-1:0]     m_count_reg;
    logic                          m_flag_reg;
    logic [COUNT_WIDTH+31:0]       cnt_ext;
    logic [PH_OUT_COUNT_W-1:0]     cnt_sat;

    // unpack request and check range
    assign pixel_value = s_axis_tdata[PH_PIXEL_W-1:0];
    assign bin_index   = s_axis_tdata[2*PH_PIXEL_W-1:PH_PIXEL_W];
    assign pix_ext     = (ADDR_W+PH_PIXEL_W)'(pixel_value);
    assign idx_ext     = (ADDR_W+PH_PIXEL_W)'(bin_index);

    always_comb
    begin
        if (s_axis_tuser == PH_CMD_COUNT)
        begin
            req_addr = pix_ext[ADDR_W-1:0];
            req_ok   = (32'(pixel_value) < NUM_BINS) && (pixel_value <= max_level_reg);
        end
        else
        begin
            req_addr = idx_ext[ADDR_W-1:0];
            req_ok   = 32'(bin_index) < NUM_BINS;
        end
    end

    // stage 1 advances unless a read result has nowhere to go
    assign s1_go = s1_valid_reg &&
                   ((s1_cmd_reg == PH_CMD_COUNT) || !m_valid_reg || m_axis_tready);
    assign s_axis_tready = !clr_ctrl.busy && (!s1_valid_reg || s1_go);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // current bin value, forwarded if written while the read was issued
    assign s1_count = fwd_hit_reg ? fwd_data_reg : ram_rd_data;

    // write back: clearing sweep or saturating increment
    assign upd_en = s1_go && (s1_cmd_reg == PH_CMD_COUNT) && s1_ok_reg &&
                    (s1_count != COUNT_MAX);

    always_comb
    begin
        if (clr_ctrl.wr_en)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr;
            ram_wr_data = '0;
        end
        else
        begin
            ram_wr_en   = upd_en;
            ram_wr_addr = s1_addr_reg;
            ram_wr_data = s1_count + 1'b1;
        end
    end

    ph_clear #(
        .NUM_BINS(NUM_BINS)
    ) u_clear (
        .clk  (clk),
        .rst_n(rst_n),
        .ctrl (clr_ctrl),
        .addr (clr_addr)
    );

    ph_ram #(
        .WIDTH(COUNT_WIDTH),
        .DEPTH(NUM_BINS)
    ) u_bins (
        .clk    (clk),
        .wr_en  (ram_wr_en),
        .wr_addr(ram_wr_addr),
        .wr_data(ram_wr_data),
        .rd_en  (accept),
        .rd_addr(req_addr),
        .rd_data(ram_rd_data)
    );

    // stage 1 control
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // capture request and forward info on accept
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg   <= s_axis_tuser;
            s1_addr_reg  <= req_addr;
            s1_ok_reg    <= req_ok;
            fwd_hit_reg  <= ram_wr_en && (ram_wr_addr == req_addr);
            fwd_data_reg <= ram_wr_data;
        end
    end

    // sticky out-of-range flag
    assign flag_next = flag_reg ||
                       (s1_go && (s1_cmd_reg == PH_CMD_COUNT) && !s1_ok_reg);

    // saturate the count to the response width; out-of-range bins read zero
    assign cnt_ext = (COUNT_WIDTH+32)'(s1_count);
    always_comb
    begin
        if (!s1_ok_reg)
        begin
            cnt_sat = '0;
        end
        else if (|cnt_ext[COUNT_WIDTH+31:PH_OUT_COUNT_W])
        begin
            cnt_sat = {PH_OUT_COUNT_W{1'b1}};
        end
        else
        begin
            cnt_sat = cnt_ext[PH_OUT_COUNT_W-1:0];
        end
    end

    // output register
    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (s1_go && (s1_cmd_reg == PH_CMD_READ))
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && (s1_cmd_reg == PH_CMD_READ))
        begin
            m_count_reg <= cnt_sat;
            m_flag_reg  <= flag_reg;
        end
    end

    // control registers and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg   <= 1'b0;
            flag_reg      <= 1'b0;
            max_level_reg <= PH_MAX_LEVEL_RESET;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
            flag_reg    <= flag_next;
            if (cfg_wr_en)
            begin
                max_level_reg <= cfg_wr_data;
            end
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {(PH_M_TDATA_W-PH_OUT_COUNT_W-1)'(0), m_flag_reg, m_count_reg};

endmodule : pixel_histogram
`default_nettype wire

// ----- tb/sv/pixel_histogram_test.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_histogram_test - self-checking bench for the pixel histogram engine
// Drives count and read requests into the engine and keeps a model of the
// bins, the sticky overflow flag and max_level. The model predicts every
// read response, and each response is checked against it. The run goes
// through several max_level settings with random stalls on both channels.
// ----------------------------------------------------------------------------
module pixel_histogram_test;

    import ph_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int IDLE_PCT    = 38;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic                  cmd;
        logic [PH_PIXEL_W-1:0] pixel;
        logic [PH_PIXEL_W-1:0] bin;
    } hist_req_t;

    typedef struct {
        logic [PH_OUT_COUNT_W-1:0] count;
        logic                      overflow;
    } bin_read_t;

    logic                    clk           = 1'b0;
    logic                    rst_n         = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [PH_S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                    s_axis_tuser  = PH_CMD_COUNT;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [PH_M_TDATA_W-1:0] m_axis_tdata;
    logic                    cfg_wr_en     = 1'b0;
    logic [PH_PIXEL_W-1:0]   cfg_wr_data   = PH_MAX_LEVEL_RESET;

    // model of the engine state
    logic [PH_OUT_COUNT_W-1:0] hist_bins [PH_NUM_BINS];
    logic                      hist_overflow  = 1'b0;
    logic [PH_PIXEL_W-1:0]     hist_max_level = PH_MAX_LEVEL_RESET;

    hist_req_t pending_reqs [$];
    bin_read_t expected_reads [$];
    hist_req_t drive_req;
    hist_req_t taken_req;
    bin_read_t want_read;
    logic      req_taken      = 1'b0;
    logic      steady_flow    = 1'b0;
    logic [PH_PIXEL_W-1:0] level_setting = PH_MAX_LEVEL_RESET;
    int        mismatch_count = 0;
    int        stall_cycles   = 0;

    pixel_histogram u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always #5 clk = ~clk;

    // request driver: present the next queued request once the last is taken
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else if (!s_axis_tvalid || req_taken)
        begin
            if (pending_reqs.size() != 0 &&
                (steady_flow || $urandom_range(99) >= IDLE_PCT))
            begin
                drive_req = pending_reqs.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {drive_req.bin, drive_req.pixel};
                s_axis_tuser  <= drive_req.cmd;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // response back-pressure
    always @(negedge clk)
    begin
        m_axis_tready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
    end

    // monitor: check responses, then update the model with accepted requests
    always @(posedge clk)
    begin
        req_taken <= s_axis_tvalid && s_axis_tready;
        if (rst_n)
        begin
            if (cfg_wr_en)
                hist_max_level = cfg_wr_data;

            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_reads.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("tb: response with no read pending, tdata %h",
                                 m_axis_tdata);
                end
                else
                begin
                    want_read = expected_reads.pop_front();
                    if (m_axis_tdata[PH_OUT_COUNT_W-1:0] !== want_read.count ||
                        m_axis_tdata[PH_OUT_COUNT_W] !== want_read.overflow)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("tb: read mismatch: count exp %0d got %0d, flag exp %b got %b",
                                     want_read.count, m_axis_tdata[PH_OUT_COUNT_W-1:0],
                                     want_read.overflow, m_axis_tdata[PH_OUT_COUNT_W]);
                    end
                end
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                taken_req.cmd   = s_axis_tuser;
                taken_req.pixel = s_axis_tdata[PH_PIXEL_W-1:0];
                taken_req.bin   = s_axis_tdata[2*PH_PIXEL_W-1:PH_PIXEL_W];
                if (taken_req.cmd == PH_CMD_COUNT)
                begin
                    // out-of-range pixels are dropped and set the sticky flag
                    if (taken_req.pixel > hist_max_level)
                        hist_overflow = 1'b1;
                    else if (hist_bins[taken_req.pixel] != '1)
                        hist_bins[taken_req.pixel]++;
                end
                else
                begin
                    want_read.count    = hist_bins[taken_req.bin];
                    want_read.overflow = hist_overflow;
                    expected_reads.push_back(want_read);
                end
            end
        end
    end

    // watchdog: end the run when neither channel moves for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic queue_count(input logic [PH_PIXEL_W-1:0] pixel);
        hist_req_t req;
        req.cmd   = PH_CMD_COUNT;
        req.pixel = pixel;
        req.bin   = PH_PIXEL_W'($urandom_range(255));
        pending_reqs.push_back(req);
    endtask

    task automatic queue_read(input logic [PH_PIXEL_W-1:0] bin);
        hist_req_t req;
        req.cmd   = PH_CMD_READ;
        req.pixel = PH_PIXEL_W'($urandom_range(255));
        req.bin   = bin;
        pending_reqs.push_back(req);
    endtask

    // pick a level: often one of bins 0 to 3, some at the max_level edge, the rest anywhere
    function automatic logic [PH_PIXEL_W-1:0] pick_level();
        int sel;
        sel = $urandom_range(99);
        if (sel < 40)
            return PH_PIXEL_W'($urandom_range(3));
        else if (sel < 55)
            return PH_PIXEL_W'(level_setting + $urandom_range(2));
        else
            return PH_PIXEL_W'($urandom_range(255));
    endfunction

    task automatic queue_random(input int num);
        for (int i = 0; i < num; i++)
        begin
            if ($urandom_range(99) < 35)
                queue_read(pick_level());
            else
                queue_count(pick_level());
        end
    endtask

    // hold until every request is taken and every response has come back
    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_reqs.size() != 0 || s_axis_tvalid || expected_reads.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_max_level(input logic [PH_PIXEL_W-1:0] level);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= level;
        level_setting = level;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial
    begin
        logic [PH_PIXEL_W-1:0] levels [7];
        levels = '{8'd255, 8'd3, 8'd0, 8'd128, 8'd254, 8'd1, 8'd0};
        foreach (hist_bins[i])
            hist_bins[i] = '0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // full range: empty bin, back-to-back hits on one bin, top bin
        queue_read(8'd0);
        queue_count(8'd0);
        queue_count(8'd0);
        queue_count(8'd0);
        queue_read(8'd0);
        queue_count(8'd255);
        queue_read(8'd255);
        queue_read(8'd128);
        queue_count(8'd7);
        queue_read(8'd7);
        wait_idle();

        // narrowest range: pixels above it set the flag, old counts stay readable
        write_max_level(8'd0);
        queue_count(8'd0);
        queue_count(8'd1);
        queue_count(8'd255);
        queue_read(8'd0);
        queue_read(8'd1);
        queue_read(8'd255);
        queue_count(8'd0);
        queue_read(8'd0);
        wait_idle();

        // random phases over several settings, one with no stalls at all
        levels[6] = PH_PIXEL_W'($urandom_range(255));
        for (int p = 0; p < 7; p++)
        begin
            write_max_level(levels[p]);
            steady_flow = (p == 3);
            if (p == 4)
            begin
                queue_random(80);
                wait_idle();
                queue_random(70);
            end
            else
            begin
                queue_random(150);
            end
            wait_idle();
        end
        steady_flow = 1'b0;
        repeat (8) @(posedge clk);

        if (mismatch_count == 0 && expected_reads.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule : pixel_histogram_test
`default_nettype wire

// ----- pixel_histogram.f -----
rtl/ph_pkg.sv
rtl/ph_ram.sv
rtl/ph_clear.sv
rtl/pixel_histogram.sv
tb/sv/pixel_histogram_test.sv
